// File: sv/bbd_pkg.sv
// bbd_pkg: shared types and constants of the bayer block demosaic
// used by the modules and interfaces of the block except bbd_ram
package bbd_pkg;

	localparam int PIXEL_BITS    = 8;
	localparam int COORD_BITS    = 11;
	localparam int DIM_BITS      = 12;
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int MAX_HEIGHT    = 2048;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [DIM_BITS-1:0] DEF_IMAGE_WIDTH  = 12'd640;
	localparam logic [DIM_BITS-1:0] DEF_IMAGE_HEIGHT = 12'd480;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [1:0] beat_t;

	localparam beat_t LAST_BEAT = 2'd3;

	// one finished 2x2 block; coordinates are of the block, pixel coordinate / 2
	typedef struct packed {
		pixel_t                red;
		pixel_t                green;
		pixel_t                blue;
		logic [COORD_BITS-2:0] bx;
		logic [COORD_BITS-2:0] by;
	} block_t;

endpackage

// File: sv/bbd_sample_if.sv
// bbd_sample_if: valid/ready channel carrying raw bayer samples
// depends on bbd_pkg
interface bbd_sample_if;
	import bbd_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// File: sv/bbd_pixel_if.sv
// bbd_pixel_if: valid/ready channel carrying reconstructed rgb pixels
// depends on bbd_pkg
interface bbd_pixel_if;
	import bbd_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t red;
	pixel_t green;
	pixel_t blue;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last;

	modport source (output valid, output red, output green, output blue,
		output pixel_x, output pixel_y, output last, input ready);
	modport sink (input valid, input red, input green, input blue,
		input pixel_x, input pixel_y, input last, output ready);
endinterface

// File: sv/bbd_ram.sv
// bbd_ram: generic single write port, single read port ram with registered read
// no dependencies
module bbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/bbd_front.sv
// bbd_front: config registers, raster counters, even-row line store and block detection
// depends on bbd_pkg, bbd_sample_if, bbd_ram
module bbd_front #(
	parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  bbd_pkg::reg_index_t            cfg_index,
	input  logic [bbd_pkg::DIM_BITS-1:0]   cfg_data,
	bbd_sample_if.sink                     samples,
	input  logic [$clog2(bbd_pkg::QUEUE_DEPTH+1)-1:0] queue_level,
	output logic                           push,
	output bbd_pkg::block_t                push_block
);
	import bbd_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int LW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RD  = MAX_WIDTH / 2;
	localparam int RAW = (RD > 1) ? $clog2(RD) : 1;

	logic [DIM_BITS-1:0] width_q, height_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	pixel_t              held_red_q;

	logic          valid_s1;
	pixel_t        red_s1;
	pixel_t        gbot_s1;
	logic [COORD_BITS-2:0] bx_s1, by_s1;

	logic [LW-1:0]  len, wblk;
	logic [HW-1:0]  rows, hblk;
	logic           acc, in_blk, last_col, last_row;
	logic [RAW-1:0] addr;
	logic           we_g, we_b;
	pixel_t         top_g, top_b;
	coord_t         x_c, y_c;
	logic [PIXEL_BITS:0] gsum;

	always_comb begin
		if (width_q < DIM_BITS'(2)) begin
			len = LW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			len = LW'(MAX_WIDTH);
		end else begin
			len = LW'(width_q);
		end
		if (height_q < DIM_BITS'(2)) begin
			rows = HW'(2);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			rows = HW'(MAX_HEIGHT);
		end else begin
			rows = HW'(height_q);
		end
	end

	assign wblk     = {len[LW-1:1], 1'b0};
	assign hblk     = {rows[HW-1:1], 1'b0};
	assign in_blk   = (32'(col_q) < 32'(wblk)) && (32'(row_q) < 32'(hblk));
	assign last_col = (32'(col_q) + 32'd1) >= 32'(len);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(rows);

	assign samples.ready = (32'(queue_level) + 32'(valid_s1)) < QUEUE_DEPTH;
	assign acc           = samples.valid && samples.ready;

	assign addr = RAW'(col_q >> 1);
	assign we_g = acc && in_blk && !row_q[0] && !col_q[0];
	assign we_b = acc && in_blk && !row_q[0] && col_q[0];
	assign x_c  = COORD_BITS'(col_q);
	assign y_c  = COORD_BITS'(row_q);

	// even column of even row: top green; odd column: blue
	bbd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RD), .AW(RAW)) u_green_store (
		.clk   (clk),
		.we    (we_g),
		.waddr (addr),
		.wdata (samples.sample),
		.raddr (addr),
		.rdata (top_g)
	);

	bbd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RD), .AW(RAW)) u_blue_store (
		.clk   (clk),
		.we    (we_b),
		.waddr (addr),
		.wdata (samples.sample),
		.raddr (addr),
		.rdata (top_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DEF_IMAGE_WIDTH;
			height_q   <= DEF_IMAGE_HEIGHT;
			col_q      <= '0;
			row_q      <= '0;
			held_red_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			valid_s1 <= acc && in_blk && row_q[0] && col_q[0];
			if (acc) begin
				if (in_blk && row_q[0] && !col_q[0]) begin
					held_red_q <= samples.sample;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			red_s1  <= held_red_q;
			gbot_s1 <= samples.sample;
			bx_s1   <= x_c[COORD_BITS-1:1];
			by_s1   <= y_c[COORD_BITS-1:1];
		end
	end

	assign gsum = {1'b0, top_g} + {1'b0, gbot_s1};

	assign push             = valid_s1;
	assign push_block.red   = red_s1;
	assign push_block.green = gsum[PIXEL_BITS:1];
	assign push_block.blue  = top_b;
	assign push_block.bx    = bx_s1;
	assign push_block.by    = by_s1;

endmodule

// File: sv/bbd_queue.sv
// bbd_queue: short fifo of finished blocks between front and back
// depends on bbd_pkg
module bbd_queue #(
	parameter int DEPTH = bbd_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bbd_pkg::block_t            push_block,
	input  logic                       pop,
	output bbd_pkg::block_t            head,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	import bbd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LV = $clog2(DEPTH + 1);

	block_t         slot_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [LV-1:0]  level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LV'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LV'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_block;
		end
	end

	assign head  = slot_q[rd_q];
	assign empty = (level_q == '0);
	assign level = level_q;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (32'(level_q) < DEPTH || pop))
		else $error("block queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("block queue underflow");

	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> level_q == $past(level_q) + LV'(1))
		else $error("block queue level mismatch");
`endif

endmodule

// File: sv/bbd_back.sv
// bbd_back: expands each queued block into four pixels behind an output register
// depends on bbd_pkg, bbd_pixel_if
module bbd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bbd_pkg::block_t head,
	input  logic            empty,
	output logic            pop,
	bbd_pixel_if.source     pixels
);
	import bbd_pkg::*;

	beat_t  beat_q;
	logic   valid_q;
	logic   load;
	pixel_t red_q, green_q, blue_q;
	coord_t x_q, y_q;
	logic   last_q;

	assign load = !empty && (!valid_q || pixels.ready);
	assign pop  = load && (beat_q == LAST_BEAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !pixels.ready);
			if (load) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	// beat order: top-left, top-right, bottom-left, bottom-right
	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= head.red;
			green_q <= head.green;
			blue_q  <= head.blue;
			x_q     <= {head.bx, beat_q[0]};
			y_q     <= {head.by, beat_q[1]};
			last_q  <= (beat_q == LAST_BEAT);
		end
	end

	assign pixels.valid   = valid_q;
	assign pixels.red     = red_q;
	assign pixels.green   = green_q;
	assign pixels.blue    = blue_q;
	assign pixels.pixel_x = x_q;
	assign pixels.pixel_y = y_q;
	assign pixels.last    = last_q;

endmodule

// File: sv/bayer_block_demosaic_top.sv
// Bayer 2x2 block demosaic. Raw samples come in raster order, one per cycle at most.
// Each completed 2x2 block leaves as four equal rgb pixels, one per cycle while the
// receiver is ready, from the output register; a four-block queue between front and
// back lets each side stall on its own. Even rows are taken at one sample per cycle
// while the queue has room. On odd rows every two samples finish a block worth four
// pixels, so once the queue fills the input slows to the pace of the pixel output. A
// block is registered in the front, then queued, then its first pixel loaded into the
// output register. The even-row line store is two rams of MAX_WIDTH/2 entries each
// (green and blue columns) with no clearing after reset.
// Dimension registers may only be written while no work is in flight.
// depends on bbd_pkg, bbd_sample_if, bbd_pixel_if, bbd_front, bbd_queue, bbd_back
module bayer_block_demosaic_top #(
	parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  bbd_pkg::reg_index_t          cfg_index,
	input  logic [bbd_pkg::DIM_BITS-1:0] cfg_data,
	bbd_sample_if.sink                   samples,
	bbd_pixel_if.source                  pixels
);
	import bbd_pkg::*;

	logic                               push, pop, empty;
	block_t                             push_block, head;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]   level;

	bbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.samples     (samples),
		.queue_level (level),
		.push        (push),
		.push_block  (push_block)
	);

	bbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_block (push_block),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.level      (level)
	);

	bbd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.pixels (pixels)
	);

endmodule

// File: bench/tb_bayer_block_demosaic_top.sv
// tb_bayer_block_demosaic_top: self-checking bench for the bayer 2x2 block demosaic
// predicts every rgb pixel from the raw sample stream and checks each pixel transfer
// depends on bbd_pkg, bbd_sample_if, bbd_pixel_if and bayer_block_demosaic_top
module tb_bayer_block_demosaic_top;
	import bbd_pkg::*;

	localparam int          CLK_PERIOD   = 10;
	localparam int          MAX_WIDTH    = DEF_MAX_WIDTH;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RANDOM_ITEMS = 210;

	typedef struct packed {
		pixel_t red;
		pixel_t green;
		pixel_t blue;
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last;
	} rgb_pixel_t;

	typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_SHUT} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	reg_index_t          cfg_index;
	logic [DIM_BITS-1:0] cfg_data;

	bbd_sample_if sample_ch();
	bbd_pixel_if  pixel_ch();

	bayer_block_demosaic_top #(.MAX_WIDTH(MAX_WIDTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.samples  (sample_ch),
		.pixels   (pixel_ch)
	);

	// predictor state
	logic [DIM_BITS-1:0] image_width  = DEF_IMAGE_WIDTH;
	logic [DIM_BITS-1:0] image_height = DEF_IMAGE_HEIGHT;
	pixel_t              line_store [0:MAX_WIDTH-1];
	pixel_t              red_hold = '0;
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;

	pixel_t      raw_samples[$];
	rgb_pixel_t  pixels_due[$];
	rgb_pixel_t  want;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	bit          sender_gaps = 1'b1;
	bit          hold_request = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned dim_clamp(input logic [DIM_BITS-1:0] v,
		input int unsigned hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic void demosaic_step(input pixel_t s);
		int unsigned len, rows, x, y, k;
		logic [PIXEL_BITS:0] green_sum;
		rgb_pixel_t px;
		len  = dim_clamp(image_width, MAX_WIDTH);
		rows = dim_clamp(image_height, MAX_HEIGHT);
		x    = col_pos;
		y    = row_pos;
		if (x < len - len % 2 && y < rows - rows % 2) begin
			if (y % 2 == 0) begin
				line_store[x] = s;
			end else if (x % 2 == 0) begin
				red_hold = s;
			end else begin
				green_sum = {1'b0, line_store[x - 1]} + {1'b0, s};
				px.red    = red_hold;
				px.green  = green_sum[PIXEL_BITS:1];
				px.blue   = line_store[x];
				for (k = 0; k < 4; k++) begin
					px.pixel_x = coord_t'(x - 1 + k % 2);
					px.pixel_y = coord_t'(y - 1 + k / 2);
					px.last    = (k == 3);
					pixels_due.push_back(px);
				end
			end
		end
		if (x + 1 >= len) begin
			col_pos = 0;
			row_pos = (y + 1 >= rows) ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
			if (pixels_due.size() == 0) begin
				$error("pixel transfer with none due: x %0d y %0d",
					pixel_ch.pixel_x, pixel_ch.pixel_y);
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				check_field("red", want.red, pixel_ch.red);
				check_field("green", want.green, pixel_ch.green);
				check_field("blue", want.blue, pixel_ch.blue);
				check_field("pixel_x", want.pixel_x, pixel_ch.pixel_x);
				check_field("pixel_y", want.pixel_y, pixel_ch.pixel_y);
				check_field("last", want.last, pixel_ch.last);
			end
		end
	end

	initial begin : pixel_receiver
		rx_mode_t mode;
		int unsigned run_left, tick;
		mode     = RX_OPEN;
		run_left = 0;
		tick     = 0;
		pixel_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pixel_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (run_left == 0) begin
					case ($urandom_range(0, 7))
						0, 1, 2, 3: begin
							mode     = RX_OPEN;
							run_left = $urandom_range(8, 60);
						end
						4, 5: begin
							mode     = RX_COIN;
							run_left = $urandom_range(4, 40);
						end
						6: begin
							mode     = RX_THIRD;
							run_left = $urandom_range(4, 40);
						end
						default: begin
							mode     = RX_SHUT;
							run_left = $urandom_range(2, 12);
						end
					endcase
				end
				run_left--;
				tick++;
				case (mode)
					RX_OPEN:  pixel_ch.ready <= 1'b1;
					RX_COIN:  pixel_ch.ready <= ($urandom_range(0, 1) == 1);
					RX_THIRD: pixel_ch.ready <= (tick % 3 == 0);
					default:  pixel_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
				(pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) || cfg_we === 1'b1)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_bayer_block_demosaic_top: FAIL");
		$finish;
	end

	task automatic set_dims(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		image_width  = w;
		image_height = h;
	endtask

	task automatic send_sample(input pixel_t value);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= value;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		demosaic_step(value);
	endtask

	// sends the queued samples, then lets the block drain so it is idle
	task automatic send_stream();
		while (raw_samples.size() != 0)
			send_sample(raw_samples.pop_front());
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pixels_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_random_samples(input int unsigned n);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0:       raw_samples.push_back(8'h00);
				1:       raw_samples.push_back(8'hFF);
				default: raw_samples.push_back(pixel_t'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// part of a row at the reset size, then a shrink that wraps the column counter
	task automatic test_default_dims();
		add_random_samples(24);
		send_stream();
		set_dims(12'd2, 12'd2);
		add_random_samples(3);
		send_stream();
	endtask

	task automatic test_directed_blocks();
		set_dims(12'd6, 12'd2);
		raw_samples = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd1, 8'd170,
			8'd255, 8'd255, 8'd0, 8'd0, 8'd85, 8'd2};
		send_stream();
		// trailing column and row give nothing
		set_dims(12'd3, 12'd3);
		raw_samples = '{8'd10, 8'd20, 8'd99, 8'd30, 8'd41, 8'd77, 8'd5, 8'd6, 8'd7};
		send_stream();
	endtask

	task automatic test_resize_mid_frame();
		set_dims(12'd8, 12'd4);
		add_random_samples(6);
		send_stream();
		// column counter now beyond the new width
		set_dims(12'd4, 12'd4);
		add_random_samples(13);
		send_stream();
	endtask

	task automatic test_output_stall();
		set_dims(12'd16, 12'd4);
		add_random_samples(64);
		sender_gaps  = 1'b0;
		hold_request = 1'b1;
		send_stream();
		sender_gaps = 1'b1;
	endtask

	// width saturates to the store size; a part row only fills the store
	task automatic test_widest_frame();
		set_dims(12'hFFF, 12'd4);
		add_random_samples(16);
		send_stream();
	endtask

	task automatic test_tallest_frame();
		set_dims(12'd0, 12'hFFF);
		add_random_samples(16);
		send_stream();
		// row counter now beyond the new height
		set_dims(12'd2, 12'd2);
		add_random_samples(1);
		send_stream();
	endtask

	task automatic test_random_frames();
		int unsigned sent, n;
		logic [DIM_BITS-1:0] w, h;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				w = DIM_BITS'($urandom_range(0, 3));
			else if ($urandom_range(0, 9) == 0)
				w = DIM_BITS'($urandom_range(13, 48));
			else
				w = DIM_BITS'($urandom_range(2, 12));
			h = ($urandom_range(0, 9) == 0) ? DIM_BITS'($urandom_range(0, 3)) :
				DIM_BITS'($urandom_range(2, 6));
			set_dims(w, h);
			n = dim_clamp(w, MAX_WIDTH) * dim_clamp(h, MAX_HEIGHT) * $urandom_range(1, 2);
			add_random_samples(n);
			send_stream();
			sent += n;
		end
	endtask

	initial begin : run_tests
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_IMAGE_WIDTH;
		cfg_data         <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_dims();
		test_directed_blocks();
		test_resize_mid_frame();
		test_output_stall();
		test_widest_frame();
		test_tallest_frame();
		test_random_frames();
		if (mismatches == 0)
			$display("tb_bayer_block_demosaic_top: PASS");
		else
			$display("tb_bayer_block_demosaic_top: FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/bbd_pkg.sv
sv/bbd_sample_if.sv
sv/bbd_pixel_if.sv
sv/bbd_ram.sv
sv/bbd_front.sv
sv/bbd_queue.sv
sv/bbd_back.sv
sv/bayer_block_demosaic_top.sv
bench/tb_bayer_block_demosaic_top.sv
